// ===== rtl/core/ssm_pkg.sv =====
// Package for the swap slot manager: sizes, codes and helpers.
package ssm_pkg;
   localparam int MaxSlots       = 4096;
   localparam int TableEntries   = 1024;
   localparam int SectorsPerSlot = 8;
   localparam int WordBits       = 32;
   localparam int WordCount      = MaxSlots / WordBits;
   localparam int WordIdxW       = $clog2(WordCount);
   localparam int BitIdxW        = $clog2(WordBits);
   localparam int SlotW          = $clog2(MaxSlots);
   localparam int EntryW         = $clog2(TableEntries);
   localparam int SectorShift    = $clog2(SectorsPerSlot);

   typedef enum logic [1:0] {
      ACT_OUT    = 2'd0,
      ACT_IN     = 2'd1,
      ACT_LOOKUP = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOTREADY = 3'd1,
      ST_NOPAGE   = 3'd2,
      ST_NOSLOT   = 3'd3,
      ST_IOERR    = 3'd4
   } status_type;

   localparam logic [12:0] SlotNone = 13'h1FFF;
endpackage

// ===== rtl/core/ssm_table.sv =====
// Page-to-slot table: linear scan for record and lookup.
module ssm_table import ssm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic        do_record,
   input  logic [19:0] key,
   input  logic [12:0] wr_slot,
   output logic        done,
   output logic        found,
   output logic [12:0] found_slot
);
   typedef enum logic [1:0] {T_IDLE, T_CLEAR, T_SCAN, T_DONE} tstate_type;

   logic [19:0] page_mem [TableEntries];
   logic [12:0] slot_mem [TableEntries];

   tstate_type    state_ff;
   logic [EntryW:0] idx_ff;     // issued address
   logic          rvalid_ff;
   logic [EntryW-1:0] raddr_ff;
   logic [19:0]   rpage_ff;
   logic [12:0]   rslot_ff;
   logic          rec_ff;
   logic          done_ff, found_ff;
   logic [12:0]   fslot_ff;
   logic          hit;

   assign done = done_ff;
   assign found = found_ff;
   assign found_slot = fslot_ff;

   always_ff @(posedge clock) begin
      rpage_ff <= page_mem[idx_ff[EntryW-1:0]];
      rslot_ff <= slot_mem[idx_ff[EntryW-1:0]];
      if (state_ff == T_CLEAR) begin
         page_mem[idx_ff[EntryW-1:0]] <= 20'd0;
         slot_mem[idx_ff[EntryW-1:0]] <= 13'd0;
      end else if (state_ff == T_SCAN && rvalid_ff && hit && rec_ff) begin
         page_mem[raddr_ff] <= key;
         slot_mem[raddr_ff] <= wr_slot;
      end
   end

   assign hit = rec_ff ? (rpage_ff == 20'd0 || rpage_ff == key) : (rpage_ff == key);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= T_CLEAR;
         idx_ff    <= '0;
         rvalid_ff <= 1'b0;
         done_ff   <= 1'b0;
         found_ff  <= 1'b0;
         rec_ff    <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            T_CLEAR: begin
               idx_ff <= idx_ff + 1'b1;
               // done pulse tells the sequencer the clearing pass is over
               if (idx_ff == (EntryW+1)'(TableEntries - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= T_IDLE;
               end
            end
            T_IDLE: begin
               idx_ff <= '0;
               rvalid_ff <= 1'b0;
               if (go) begin
                  rec_ff   <= do_record;
                  state_ff <= T_SCAN;
               end
            end
            T_SCAN: begin
               if (rvalid_ff && hit) begin
                  found_ff <= 1'b1;
                  fslot_ff <= rslot_ff;
                  done_ff  <= 1'b1;
                  state_ff <= T_DONE;
               end else if (rvalid_ff && raddr_ff == EntryW'(TableEntries - 1)) begin
                  found_ff <= 1'b0;
                  done_ff  <= 1'b1;
                  state_ff <= T_DONE;
               end else begin
                  rvalid_ff <= !idx_ff[EntryW];
                  raddr_ff  <= idx_ff[EntryW-1:0];
                  if (!idx_ff[EntryW]) idx_ff <= idx_ff + 1'b1;
               end
            end
            T_DONE: begin
               rvalid_ff <= 1'b0;
               state_ff  <= T_IDLE;
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/core/swap_slot_manager.sv =====
// Swap slot manager top level: bitmap allocator, sequencer and counters.
// A bitmap scan reads one 32-bit word per cycle (up to 128 words) and the
// table scan one entry per cycle (up to 1024). One transaction at a time;
// busy is high while working.
// After reset a clearing pass over the bitmap and the table runs with busy high.
// Results show for one cycle on rsp_valid; the receiver cannot stall.
module swap_slot_manager import ssm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_action,
   input  logic [19:0]  req_page_number,
   input  logic [11:0]  req_slot_index,
   input  logic         req_page_ok,
   input  logic         req_transfer_ok,
   output logic         rsp_valid,
   output logic [2:0]   rsp_status,
   output logic signed [12:0] rsp_slot_result,
   output logic [31:0]  rsp_sector_address,
   output logic [31:0]  rsp_pages_out_total,
   output logic [31:0]  rsp_pages_in_total,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_INRD, S_INWR, S_TABLE, S_WAIT
   } state_type;

   logic [WordBits-1:0] map_mem [WordCount];
   logic [WordBits-1:0] rword_ff;

   state_type state_ff;
   logic        en_ff;
   logic [12:0] lim_ff;
   logic [31:0] base_ff;
   logic [31:0] outc_ff, inc_ff;
   action_type  act_ff;
   logic [19:0] page_ff;
   logic [11:0] sidx_ff;
   logic        xok_ff;
   logic [WordIdxW:0] widx_ff;
   logic [WordIdxW-1:0] raddr_ff;
   logic        rvalid_ff;
   logic        mwe;
   logic [WordIdxW-1:0] mwaddr;
   logic [WordBits-1:0] mwdata;
   logic [12:0] lim;
   logic        tgo, trec, tdone, tfound;
   logic [12:0] tslot, twslot;
   logic        zfound;
   logic [BitIdxW-1:0] zbit;
   logic [12:0] cand;

   logic        rv_ff;
   logic [2:0]  rst_ff;
   logic [12:0] rslot_ff;

   assign lim = (lim_ff > 13'(MaxSlots)) ? 13'(MaxSlots) : lim_ff;
   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_status = rst_ff;
   assign rsp_slot_result = rslot_ff;
   assign rsp_pages_out_total = outc_ff;
   assign rsp_pages_in_total = inc_ff;

   function automatic logic [31:0] sector_of(input logic [31:0] b, input logic [12:0] s);
      return b + (32'(s) << SectorShift);
   endfunction

   // lowest zero bit of the read word
   always_comb begin
      zfound = 1'b0;
      zbit   = '0;
      for (int k = WordBits - 1; k >= 0; k--) begin
         if (!rword_ff[k]) begin
            zfound = 1'b1;
            zbit   = BitIdxW'(k);
         end
      end
   end
   assign cand = {1'b0, raddr_ff, zbit};

   always_ff @(posedge clock) begin
      rword_ff <= map_mem[widx_ff[WordIdxW-1:0]];
      if (mwe) map_mem[mwaddr] <= mwdata;
   end

   ssm_table u_table (
      .clock, .reset, .go(tgo), .do_record(trec), .key(page_ff),
      .wr_slot(twslot), .done(tdone), .found(tfound), .found_slot(tslot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         en_ff <= 1'b0; lim_ff <= '0; base_ff <= '0;
         outc_ff <= '0; inc_ff <= '0;
         widx_ff <= '0; rvalid_ff <= 1'b0; rv_ff <= 1'b0;
         tgo <= 1'b0; trec <= 1'b0; mwe <= 1'b0;
      end else begin
         rv_ff <= 1'b0;
         tgo   <= 1'b0;
         mwe   <= 1'b0;
         if (csr_write) begin
            unique case (csr_index)
               2'd0: en_ff <= csr_data[0];
               2'd1: lim_ff <= csr_data[12:0];
               2'd2: base_ff <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_CLEAR: begin
               mwe <= 1'b1; mwaddr <= widx_ff[WordIdxW-1:0]; mwdata <= '0;
               widx_ff <= widx_ff + 1'b1;
               if (widx_ff == (WordIdxW+1)'(WordCount - 1)) state_ff <= S_WAIT;
            end
            S_WAIT: begin
               // table clearing pass ends with a done pulse
               widx_ff <= '0;
               if (tdone) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               trec <= 1'b1;
               widx_ff <= '0; rvalid_ff <= 1'b0;
               if (start) begin
                  act_ff <= action_type'(req_action);
                  page_ff <= req_page_number; sidx_ff <= req_slot_index;
                  xok_ff <= req_transfer_ok;
                  rst_ff <= ST_OK; rslot_ff <= SlotNone; rsp_sector_address <= '0;
                  priority if (req_action == ACT_NONE) begin
                     rv_ff <= 1'b1;
                  end else if (req_action == ACT_LOOKUP) begin
                     tgo <= 1'b1; trec <= 1'b0; state_ff <= S_TABLE;
                  end else if (!en_ff) begin
                     rst_ff <= ST_NOTREADY; rv_ff <= 1'b1;
                  end else if (!req_page_ok) begin
                     rst_ff <= ST_NOPAGE; rv_ff <= 1'b1;
                  end else if (req_action == ACT_IN) begin
                     rslot_ff <= {1'b0, req_slot_index};
                     rsp_sector_address <= sector_of(base_ff, {1'b0, req_slot_index});
                     if (!req_transfer_ok) begin
                        rst_ff <= ST_IOERR; rv_ff <= 1'b1;
                     end else begin
                        widx_ff <= (WordIdxW+1)'(req_slot_index >> BitIdxW);
                        state_ff <= S_INRD;
                     end
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_INRD: state_ff <= S_INWR;   // word read in flight
            S_INWR: begin
               if ({1'b0, sidx_ff} < lim) begin
                  mwe <= 1'b1; mwaddr <= widx_ff[WordIdxW-1:0];
                  mwdata <= rword_ff & ~(WordBits'(1) << sidx_ff[BitIdxW-1:0]);
               end
               inc_ff <= inc_ff + 1'b1;
               twslot <= SlotNone; trec <= 1'b1; tgo <= 1'b1;
               state_ff <= S_TABLE;
            end
            S_SCAN: begin
               if (rvalid_ff && zfound && cand < lim) begin
                  rslot_ff <= cand;
                  rsp_sector_address <= sector_of(base_ff, cand);
                  if (!xok_ff) begin
                     rst_ff <= ST_IOERR; rv_ff <= 1'b1; state_ff <= S_IDLE;
                  end else begin
                     mwe <= 1'b1; mwaddr <= raddr_ff;
                     mwdata <= rword_ff | (WordBits'(1) << zbit);
                     outc_ff <= outc_ff + 1'b1;
                     twslot <= cand; trec <= 1'b1; tgo <= 1'b1;
                     state_ff <= S_TABLE;
                  end
               end else if ((rvalid_ff && {1'b0, raddr_ff, {BitIdxW{1'b1}}} >= lim - 13'd1)
                            || lim == 13'd0) begin
                  rst_ff <= ST_NOSLOT; rv_ff <= 1'b1; state_ff <= S_IDLE;
               end else begin
                  rvalid_ff <= 1'b1;
                  raddr_ff  <= widx_ff[WordIdxW-1:0];
                  widx_ff   <= widx_ff + 1'b1;
               end
            end
            S_TABLE: begin
               if (tdone) begin
                  if (act_ff == ACT_LOOKUP) begin
                     if (tfound && !tslot[12]) begin
                        rslot_ff <= tslot;
                        rsp_sector_address <= sector_of(base_ff, tslot);
                     end else if (tfound) begin
                        rslot_ff <= tslot;
                     end
                  end
                  rv_ff <= 1'b1; state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
